/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Checks compile out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* src/ccfd_pkg.sv */
package ccfd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int CRC_BYTES    = 2;
    localparam int POS_W        = 17;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Fixed header positions
    localparam logic [POS_W-1:0] POS_START_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_START_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_VERSION      = POS_W'(2);
    localparam logic [POS_W-1:0] POS_TYPE         = POS_W'(3);
    localparam logic [POS_W-1:0] POS_SEQ_LO       = POS_W'(4);
    localparam logic [POS_W-1:0] POS_SEQ_HI       = POS_W'(5);
    localparam logic [POS_W-1:0] POS_LEN_LO       = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LEN_HI       = POS_W'(7);
    localparam logic [POS_W-1:0] POS_PAYLOAD      = POS_W'(HEADER_BYTES);
    // Position of the final byte in the shortest legal frame
    localparam logic [POS_W-1:0] POS_MIN_LAST     = POS_W'(HEADER_BYTES + CRC_BYTES - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = CFG_IDX_W'(3);

    localparam logic [7:0]  RST_START_FIRST  = 8'h00;
    localparam logic [7:0]  RST_START_SECOND = 8'h00;
    localparam logic [7:0]  RST_VERSION      = 8'h01;
    localparam logic [15:0] RST_MAX_PAYLOAD  = 16'd256;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_BAD_START    = 3'd2,
        ST_BAD_VERSION  = 3'd3,
        ST_TOO_LARGE    = 3'd4,
        ST_LEN_MISMATCH = 3'd5,
        ST_CRC_MISMATCH = 3'd6
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0]  start_byte_first;
        logic [7:0]  start_byte_second;
        logic [7:0]  protocol_version;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_type;
        logic [15:0] sequence_number;
        logic [15:0] payload_length;
        t_status     status_code;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
    } t_result;

    // CRC-16/MODBUS, one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* src/ccfd_regs.sv */
module ccfd_regs
    import ccfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_FIRST:  n_cfg.start_byte_first  = i_cfg_data[7:0];
                CFG_START_SECOND: n_cfg.start_byte_second = i_cfg_data[7:0];
                CFG_VERSION:      n_cfg.protocol_version  = i_cfg_data[7:0];
                CFG_MAX_PAYLOAD:  n_cfg.max_payload       = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte_first  <= RST_START_FIRST;
            r_cfg.start_byte_second <= RST_START_SECOND;
            r_cfg.protocol_version  <= RST_VERSION;
            r_cfg.max_payload       <= RST_MAX_PAYLOAD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* src/ccfd_parse.sv */
`include "assert_macros.svh"

module ccfd_parse
    import ccfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_frame,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [POS_W-1:0] r_pos,      n_pos;
    logic [15:0]      r_crc,      n_crc;
    logic             r_start_ok, n_start_ok;
    logic             r_ver_ok,   n_ver_ok;
    logic [7:0]       r_type,     n_type;
    logic [15:0]      r_seq,      n_seq;
    logic [15:0]      r_len,      n_len;
    logic [15:0]      r_rx_crc,   n_rx_crc;

    logic [POS_W-1:0] payload_end;
    logic             in_payload;
    t_status          status;

    assign payload_end = POS_PAYLOAD + {1'b0, r_len};
    assign in_payload  = (r_pos >= POS_PAYLOAD) && (r_pos < payload_end);

    // Frame state update for the byte on the input
    always_comb begin
        n_start_ok = r_start_ok;
        n_ver_ok   = r_ver_ok;
        n_type     = r_type;
        n_seq      = r_seq;
        n_len      = r_len;
        case (r_pos)
            POS_START_FIRST:  if (i_data_byte != i_cfg.start_byte_first)  n_start_ok = 1'b0;
            POS_START_SECOND: if (i_data_byte != i_cfg.start_byte_second) n_start_ok = 1'b0;
            POS_VERSION:      n_ver_ok = (i_data_byte == i_cfg.protocol_version);
            POS_TYPE:         n_type   = i_data_byte;
            POS_SEQ_LO:       n_seq    = {r_seq[15:8], i_data_byte};
            POS_SEQ_HI:       n_seq    = {i_data_byte, r_seq[7:0]};
            POS_LEN_LO:       n_len    = {r_len[15:8], i_data_byte};
            POS_LEN_HI:       n_len    = {i_data_byte, r_len[7:0]};
            default:          n_type   = r_type;
        endcase

        if (r_pos >= POS_VERSION && (r_pos < POS_PAYLOAD || in_payload)) begin
            n_crc = crc16_byte(r_crc, i_data_byte);
        end else begin
            n_crc = r_crc;
        end

        n_rx_crc = {i_data_byte, r_rx_crc[15:8]};
        n_pos    = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
    end

    // Status of a frame ending on this byte, first failing check wins
    always_comb begin
        if (r_pos < POS_MIN_LAST) begin
            status = ST_SHORT;
        end else if (!n_start_ok) begin
            status = ST_BAD_START;
        end else if (!n_ver_ok) begin
            status = ST_BAD_VERSION;
        end else if (n_len > i_cfg.max_payload) begin
            status = ST_TOO_LARGE;
        end else if (r_pos != ({1'b0, n_len} + POS_MIN_LAST)) begin
            status = ST_LEN_MISMATCH;
        end else if (n_rx_crc != n_crc) begin
            status = ST_CRC_MISMATCH;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_res       = '0;
        o_res_valid = 1'b0;
        if (i_end_of_frame) begin
            o_res_valid           = i_accept;
            o_res.kind            = KIND_STATUS;
            o_res.frame_type      = n_type;
            o_res.sequence_number = n_seq;
            o_res.payload_length  = n_len;
            o_res.status_code     = status;
            o_res.received_crc    = n_rx_crc;
            o_res.computed_crc    = n_crc;
        end else if (in_payload && (r_len <= i_cfg.max_payload)) begin
            o_res_valid         = i_accept;
            o_res.kind          = KIND_PAYLOAD;
            o_res.payload_byte  = i_data_byte;
            o_res.payload_index = 16'(r_pos - POS_PAYLOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_end_of_frame)) begin
            r_pos      <= '0;
            r_crc      <= CRC_INIT;
            r_start_ok <= 1'b1;
            r_ver_ok   <= 1'b1;
            r_type     <= '0;
            r_seq      <= '0;
            r_len      <= '0;
            r_rx_crc   <= '0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_start_ok <= n_start_ok;
            r_ver_ok   <= n_ver_ok;
            r_type     <= n_type;
            r_seq      <= n_seq;
            r_len      <= n_len;
            r_rx_crc   <= n_rx_crc;
        end
    end

    `ASSERT_CLK(a_eof_restarts_frame, i_clk, i_rst_n, (i_accept && i_end_of_frame) |=> (r_pos == '0 && r_crc == CRC_INIT))
    `ASSERT_CLK(a_pos_advances, i_clk, i_rst_n, (i_accept && !i_end_of_frame && r_pos != POS_MAX) |=> (r_pos == $past(r_pos) + POS_W'(1)))
    `ASSERT_NEVER(a_payload_in_header, i_clk, i_rst_n, o_res_valid && o_res.kind == KIND_PAYLOAD && r_pos < POS_PAYLOAD)

endmodule

/* src/ccfd_out_buf.sv */
`include "assert_macros.svh"

module ccfd_out_buf
    import ccfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_stall
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;
    // Skid entry busy: hold off new items
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_res;
            end else begin
                r_main <= i_res;
            end
        end
    end

    `ASSERT_NEVER(a_skid_without_main, i_clk, i_rst_n, r_skid_valid && !r_main_valid)
    `ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, i_push && r_skid_valid)
    `ASSERT_CLK(a_skid_drains, i_clk, i_rst_n, (r_skid_valid && pop) |=> (r_main_valid && !r_skid_valid))

endmodule

/* src/crc_checked_frame_deframer.sv */
// Frame deframer with CRC-16/MODBUS check. Takes one frame byte per cycle
// while o_in_stall is low, no gap needed between frames; i_end_of_frame
// flags the last byte. Each payload byte of a frame whose length is within
// the configured maximum comes out as a registered kind-0 result, and the
// last byte of the frame gives one kind-1 status result (type, sequence,
// length, error code, carried and computed CRC) in place of any payload
// byte. The CRC is updated a whole byte per cycle, so input and output each
// run at one transfer per cycle when not stalled; a two-entry output buffer
// keeps the input moving while one entry is free and raises o_in_stall only
// once both entries are full. Payload of a frame whose status is not ok must
// be discarded. Configuration registers are to be written through the cfg
// port only while no frame is in flight; the block does not enforce this.
module crc_checked_frame_deframer
    import ccfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_frame,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic [7:0]           o_payload_byte,
    output logic [15:0]          o_payload_index,
    output logic [7:0]           o_frame_type,
    output logic [15:0]          o_sequence_number,
    output logic [15:0]          o_payload_length,
    output logic [2:0]           o_status_code,
    output logic [15:0]          o_received_crc,
    output logic [15:0]          o_computed_crc
);

    t_cfg    cfg;
    t_result res;
    t_result out_res;
    logic    res_valid;
    logic    buf_full;
    logic    in_accept;

    assign in_accept  = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    ccfd_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    ccfd_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_data_byte    (i_data_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_cfg          (cfg),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    ccfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .i_stall (i_out_stall)
    );

    assign o_kind            = out_res.kind;
    assign o_payload_byte    = out_res.payload_byte;
    assign o_payload_index   = out_res.payload_index;
    assign o_frame_type      = out_res.frame_type;
    assign o_sequence_number = out_res.sequence_number;
    assign o_payload_length  = out_res.payload_length;
    assign o_status_code     = out_res.status_code;
    assign o_received_crc    = out_res.received_crc;
    assign o_computed_crc    = out_res.computed_crc;

endmodule
